// ===== rtl/pose_relative_direction_rotation_assert.svh =====
// assertion macros for the pose relative direction rotation block
`ifndef POSE_RELATIVE_DIRECTION_ROTATION_ASSERT_SVH
`define POSE_RELATIVE_DIRECTION_ROTATION_ASSERT_SVH

// checked outside reset
`define PRDR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("prdr assertion failed");

// checked during reset too
`define PRDR_ASSERT_NR(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("prdr assertion failed");

`endif

// ===== rtl/prdr_pkg.sv =====
// types and constants shared by the pose relative direction rotation block
package prdr_pkg;

   localparam int Q14_W       = 16;
   localparam int POS_W       = 32;
   localparam int FRAC_W      = 14;
   localparam int Q14_ONE     = 16384;
   localparam int ROUND_HALF  = 1 << (FRAC_W - 1);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int LANES       = 4;
   localparam int WIDE_W      = 45;
   localparam int MAG_W       = WIDE_W;
   localparam int MSB_W       = 6;
   localparam int NORM_W      = 30;
   localparam int NORM_MSB    = NORM_W - 1;
   localparam int SQR_W       = 2 * NORM_W;
   localparam int SUM_W       = SQR_W + 2;
   localparam int SQRT_STEPS  = SUM_W / 2;
   localparam int ROOT_W      = SQRT_STEPS;
   localparam int QUO_W       = 16;
   localparam int REM_W       = 47;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REF_X = 2'd0,
      CSR_REF_Y = 2'd1,
      CSR_REF_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [Q14_W-1:0] rot_x;
      logic signed [Q14_W-1:0] rot_y;
      logic signed [Q14_W-1:0] rot_z;
      logic signed [Q14_W-1:0] rot_w;
      logic signed [POS_W-1:0] trans_x;
      logic signed [POS_W-1:0] trans_y;
      logic signed [POS_W-1:0] trans_z;
      logic signed [POS_W-1:0] target_x;
      logic signed [POS_W-1:0] target_y;
      logic signed [POS_W-1:0] target_z;
   } req_data_type;

   typedef struct packed {
      logic signed [Q14_W-1:0] out_x;
      logic signed [Q14_W-1:0] out_y;
      logic signed [Q14_W-1:0] out_z;
      logic signed [Q14_W-1:0] out_w;
      logic                    degenerate;
   } rsp_data_type;

   typedef logic signed [WIDE_W-1:0] prdr_wide_type;
   typedef logic signed [Q14_W-1:0]  prdr_q14_type;

   typedef struct packed {
      logic signed [Q14_W-1:0] x;
      logic signed [Q14_W-1:0] y;
      logic signed [Q14_W-1:0] z;
      logic signed [Q14_W-1:0] w;
      logic                    ok;
   } prdr_side_type;

   typedef struct packed {
      logic                             valid;
      prdr_wide_type [LANES-1:0]        comp;
      prdr_side_type                    side;
   } prdr_unit_in_type;

   typedef struct packed {
      logic                             valid;
      logic                             ok;
      prdr_q14_type [LANES-1:0]         comp;
      prdr_side_type                    side;
   } prdr_unit_out_type;

endpackage

// ===== rtl/prdr_unit.sv =====
// pipelined unit-length scaling of a four component vector to q2.14
module prdr_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  prdr_pkg::prdr_unit_in_type   in_data,
   output prdr_pkg::prdr_unit_out_type  out_data
);
   import prdr_pkg::*;

   function automatic logic [MSB_W-1:0] msb_of(input logic [MAG_W-1:0] a);
      logic [MSB_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (a[i]) pos = MSB_W'(i);
      end
      return pos;
   endfunction

   // magnitudes
   logic                 s1_valid_ff;
   logic [MAG_W-1:0]     s1_mag_ff [LANES];
   logic [MAG_W-1:0]     s1_mag_in [LANES];
   logic [LANES-1:0]     s1_neg_ff, s1_neg_in;
   prdr_side_type        s1_side_ff;

   // largest magnitude
   logic                 s2_valid_ff;
   logic [MAG_W-1:0]     s2_mag_ff [LANES];
   logic [LANES-1:0]     s2_neg_ff;
   prdr_side_type        s2_side_ff;
   logic [MAG_W-1:0]     s2_max_ff, s2_max_in, m01, m23;

   // leading one
   logic                 s3_valid_ff;
   logic [MAG_W-1:0]     s3_mag_ff [LANES];
   logic [LANES-1:0]     s3_neg_ff;
   prdr_side_type        s3_side_ff;
   logic [MSB_W-1:0]     s3_msb_ff;
   logic                 s3_ok_ff;

   // normalized
   logic                 s4_valid_ff;
   logic [NORM_W-1:0]    s4_norm_ff [LANES];
   logic [NORM_W-1:0]    s4_norm_in [LANES];
   logic [LANES-1:0]     s4_neg_ff;
   prdr_side_type        s4_side_ff;
   logic                 s4_ok_ff;

   // squares
   logic                 s5_valid_ff;
   logic [SQR_W-1:0]     s5_sq_ff [LANES];
   logic [SQR_W-1:0]     s5_sq_in [LANES];
   logic [NORM_W-1:0]    s5_norm_ff [LANES];
   logic [LANES-1:0]     s5_neg_ff;
   prdr_side_type        s5_side_ff;
   logic                 s5_ok_ff;
   logic [SUM_W-1:0]     rt_sum_in;

   // square root, one result bit per stage
   logic                 rt_valid_ff [SQRT_STEPS+1];
   logic [SUM_W-1:0]     rt_x_ff     [SQRT_STEPS+1];
   logic [SUM_W-1:0]     rt_r_ff     [SQRT_STEPS+1];
   logic [SUM_W-1:0]     rt_x_in     [1:SQRT_STEPS];
   logic [SUM_W-1:0]     rt_r_in     [1:SQRT_STEPS];
   logic [NORM_W-1:0]    rt_norm_ff  [SQRT_STEPS+1][LANES];
   logic [LANES-1:0]     rt_neg_ff   [SQRT_STEPS+1];
   logic                 rt_ok_ff    [SQRT_STEPS+1];
   prdr_side_type        rt_side_ff  [SQRT_STEPS+1];

   // division, one quotient bit per stage
   logic                 dv_valid_ff [QUO_W+1];
   logic [REM_W-1:0]     dv_rem_ff   [QUO_W+1][LANES];
   logic [REM_W-1:0]     dv_rem_in   [QUO_W+1][LANES];
   logic [QUO_W-1:0]     dv_quo_ff   [QUO_W+1][LANES];
   logic [QUO_W-1:0]     dv_quo_in   [1:QUO_W][LANES];
   logic [ROOT_W-1:0]    dv_den_ff   [QUO_W+1];
   logic [LANES-1:0]     dv_neg_ff   [QUO_W+1];
   logic                 dv_ok_ff    [QUO_W+1];
   prdr_side_type        dv_side_ff  [QUO_W+1];

   prdr_unit_out_type    out_ff, out_in;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         s1_neg_in[i] = in_data.comp[i][WIDE_W-1];
         s1_mag_in[i] = s1_neg_in[i] ? (~in_data.comp[i] + 1'b1) : in_data.comp[i];
      end
      m01       = (s1_mag_ff[0] > s1_mag_ff[1]) ? s1_mag_ff[0] : s1_mag_ff[1];
      m23       = (s1_mag_ff[2] > s1_mag_ff[3]) ? s1_mag_ff[2] : s1_mag_ff[3];
      s2_max_in = (m01 > m23) ? m01 : m23;
      for (int i = 0; i < LANES; i++) begin
         if (s3_msb_ff < MSB_W'(NORM_MSB)) begin
            s4_norm_in[i] = NORM_W'(s3_mag_ff[i] << (MSB_W'(NORM_MSB) - s3_msb_ff));
         end else begin
            s4_norm_in[i] = NORM_W'(s3_mag_ff[i] >> (s3_msb_ff - MSB_W'(NORM_MSB)));
         end
         s5_sq_in[i] = s4_norm_ff[i] * s4_norm_ff[i];
      end
      rt_sum_in = SUM_W'(s5_sq_ff[0]) + SUM_W'(s5_sq_ff[1])
                + SUM_W'(s5_sq_ff[2]) + SUM_W'(s5_sq_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
         s5_valid_ff    <= 1'b0;
         rt_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         s1_valid_ff    <= in_data.valid;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         s4_valid_ff    <= s3_valid_ff;
         s5_valid_ff    <= s4_valid_ff;
         rt_valid_ff[0] <= s5_valid_ff;
      end
      if (adv) begin
         s1_mag_ff     <= s1_mag_in;
         s1_neg_ff     <= s1_neg_in;
         s1_side_ff    <= in_data.side;
         s2_mag_ff     <= s1_mag_ff;
         s2_neg_ff     <= s1_neg_ff;
         s2_side_ff    <= s1_side_ff;
         s2_max_ff     <= s2_max_in;
         s3_mag_ff     <= s2_mag_ff;
         s3_neg_ff     <= s2_neg_ff;
         s3_side_ff    <= s2_side_ff;
         s3_msb_ff     <= msb_of(s2_max_ff);
         s3_ok_ff      <= (s2_max_ff != '0);
         s4_norm_ff    <= s4_norm_in;
         s4_neg_ff     <= s3_neg_ff;
         s4_side_ff    <= s3_side_ff;
         s4_ok_ff      <= s3_ok_ff;
         s5_sq_ff      <= s5_sq_in;
         s5_norm_ff    <= s4_norm_ff;
         s5_neg_ff     <= s4_neg_ff;
         s5_side_ff    <= s4_side_ff;
         s5_ok_ff      <= s4_ok_ff;
         rt_x_ff[0]    <= rt_sum_in;
         rt_r_ff[0]    <= '0;
         rt_norm_ff[0] <= s5_norm_ff;
         rt_neg_ff[0]  <= s5_neg_ff;
         rt_ok_ff[0]   <= s5_ok_ff;
         rt_side_ff[0] <= s5_side_ff;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
      localparam int BIT_POS = SUM_W - 2 - 2 * k;
      logic [SUM_W-1:0] trial;
      assign trial = rt_r_ff[k] + (SUM_W'(1) << BIT_POS);
      always_comb begin
         if (rt_x_ff[k] >= trial) begin
            rt_x_in[k+1] = rt_x_ff[k] - trial;
            rt_r_in[k+1] = (rt_r_ff[k] >> 1) + (SUM_W'(1) << BIT_POS);
         end else begin
            rt_x_in[k+1] = rt_x_ff[k];
            rt_r_in[k+1] = rt_r_ff[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            rt_valid_ff[k+1] <= rt_valid_ff[k];
         end
         if (adv) begin
            rt_x_ff[k+1]    <= rt_x_in[k+1];
            rt_r_ff[k+1]    <= rt_r_in[k+1];
            rt_norm_ff[k+1] <= rt_norm_ff[k];
            rt_neg_ff[k+1]  <= rt_neg_ff[k];
            rt_ok_ff[k+1]   <= rt_ok_ff[k];
            rt_side_ff[k+1] <= rt_side_ff[k];
         end
      end
   end

   // dividend is mag * 2^14 + floor(n / 2)
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         dv_rem_in[0][i] = (REM_W'(rt_norm_ff[SQRT_STEPS][i]) << FRAC_W)
                         + REM_W'(rt_r_ff[SQRT_STEPS] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= rt_valid_ff[SQRT_STEPS];
      end
      if (adv) begin
         dv_rem_ff[0]  <= dv_rem_in[0];
         for (int i = 0; i < LANES; i++) begin
            dv_quo_ff[0][i] <= '0;
         end
         dv_den_ff[0]  <= rt_r_ff[SQRT_STEPS][ROOT_W-1:0];
         dv_neg_ff[0]  <= rt_neg_ff[SQRT_STEPS];
         dv_ok_ff[0]   <= rt_ok_ff[SQRT_STEPS];
         dv_side_ff[0] <= rt_side_ff[SQRT_STEPS];
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      localparam int QB = QUO_W - 1 - j;
      logic [REM_W-1:0] trial;
      assign trial = REM_W'(dv_den_ff[j]) << QB;
      always_comb begin
         for (int i = 0; i < LANES; i++) begin
            if (dv_rem_ff[j][i] >= trial) begin
               dv_rem_in[j+1][i] = dv_rem_ff[j][i] - trial;
               dv_quo_in[j+1][i] = dv_quo_ff[j][i] | (QUO_W'(1) << QB);
            end else begin
               dv_rem_in[j+1][i] = dv_rem_ff[j][i];
               dv_quo_in[j+1][i] = dv_quo_ff[j][i];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
         if (adv) begin
            dv_rem_ff[j+1]  <= dv_rem_in[j+1];
            dv_quo_ff[j+1]  <= dv_quo_in[j+1];
            dv_den_ff[j+1]  <= dv_den_ff[j];
            dv_neg_ff[j+1]  <= dv_neg_ff[j];
            dv_ok_ff[j+1]   <= dv_ok_ff[j];
            dv_side_ff[j+1] <= dv_side_ff[j];
         end
      end
   end

   always_comb begin
      out_in.valid = dv_valid_ff[QUO_W];
      out_in.ok    = dv_ok_ff[QUO_W];
      out_in.side  = dv_side_ff[QUO_W];
      for (int i = 0; i < LANES; i++) begin
         if (!dv_ok_ff[QUO_W]) begin
            out_in.comp[i] = '0;
         end else if (dv_neg_ff[QUO_W][i]) begin
            out_in.comp[i] = ~dv_quo_ff[QUO_W][i] + 1'b1;
         end else begin
            out_in.comp[i] = dv_quo_ff[QUO_W][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         out_ff.valid <= out_in.valid;
      end
      if (adv) begin
         out_ff.ok   <= out_in.ok;
         out_ff.comp <= out_in.comp;
         out_ff.side <= out_in.side;
      end
   end

   assign out_data = out_ff;

endmodule

// ===== rtl/pose_relative_direction_rotation.sv =====
// pose relative direction rotation: shortest-arc rotation toward a target in the pose frame
// throughput: one transaction per cycle; the whole pipeline halts while a result is stalled
// the 31-stage square root and 16-stage divider in each of two scaling units set the depth
// reset: synchronous, clears all valid bits, reference direction returns to (0, 0, 1)
module pose_relative_direction_rotation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  prdr_pkg::req_data_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output prdr_pkg::rsp_data_type               rsp_data,
   input  logic                                 csr_we,
   input  logic [prdr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [prdr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import prdr_pkg::*;

`include "pose_relative_direction_rotation_assert.svh"

   localparam int V_W  = POS_W + 1;
   localparam int P1_W = Q14_W + V_W;
   localparam int S1_W = P1_W + 2;
   localparam int C_W  = S1_W - FRAC_W;
   localparam int P2_W = Q14_W + C_W;
   localparam int S2_W = P2_W + 2;
   localparam int PQ_W = 2 * Q14_W;
   localparam int HS_W = PQ_W + 2;
   localparam logic signed [Q14_W-1:0] Q14_POS = Q14_W'(Q14_ONE);
   localparam logic signed [Q14_W-1:0] Q14_NEG = Q14_W'(-Q14_ONE);

   function automatic logic signed [Q14_W-1:0] clamp_q14(input logic signed [HS_W-1:0] a);
      logic signed [HS_W-1:0] sh;
      sh = (a + HS_W'(ROUND_HALF)) >>> FRAC_W;
      if (sh > HS_W'(Q14_ONE)) return Q14_POS;
      if (sh < -HS_W'(Q14_ONE)) return Q14_NEG;
      return sh[Q14_W-1:0];
   endfunction

   logic adv;
   logic signed [Q14_W-1:0] ref_x_ff, ref_y_ff, ref_z_ff;

   logic                    p1_valid_ff;
   prdr_side_type           p1_q_ff, p1_q_in;
   logic signed [V_W-1:0]   p1_v_ff [3];
   logic signed [V_W-1:0]   p1_v_in [3];

   logic                    p2_valid_ff;
   prdr_side_type           p2_q_ff;
   logic signed [V_W-1:0]   p2_v_ff [3];
   logic signed [P1_W-1:0]  p2_t_ff [3][3];
   logic signed [P1_W-1:0]  p2_t_in [3][3];

   logic                    p3_valid_ff;
   prdr_side_type           p3_q_ff;
   logic signed [V_W-1:0]   p3_v_ff [3];
   logic signed [C_W-1:0]   p3_c_ff [3];
   logic signed [C_W-1:0]   p3_c_in [3];

   logic                    p4_valid_ff;
   prdr_side_type           p4_q_ff;
   logic signed [V_W-1:0]   p4_v_ff [3];
   logic signed [P2_W-1:0]  p4_t_ff [3][2];
   logic signed [P2_W-1:0]  p4_t_in [3][2];

   logic                    p5_valid_ff;
   prdr_side_type           p5_q_ff;
   logic signed [WIDE_W-1:0] p5_w_ff [3];
   logic signed [WIDE_W-1:0] p5_w_in [3];

   prdr_unit_in_type        ua_in, ub_in;
   prdr_unit_out_type       ua_out, ub_out;

   logic                    p6_valid_ff;
   prdr_side_type           p6_q_ff, p6_q_in;
   logic signed [PQ_W-1:0]  p6_t_ff [9];
   logic signed [PQ_W-1:0]  p6_t_in [9];

   logic                    p7_valid_ff;
   prdr_side_type           p7_q_ff;
   logic signed [WIDE_W-1:0] p7_sq_ff [LANES];
   logic signed [WIDE_W-1:0] p7_sq_in [LANES];

   logic                    p8_valid_ff;
   logic                    p8_degen_ff, p8_degen_in;
   logic signed [PQ_W-1:0]  p8_t_ff [4][4];
   logic signed [PQ_W-1:0]  p8_t_in [4][4];
   logic signed [Q14_W-1:0] s_sel [LANES];

   logic                    rsp_valid_ff;
   rsp_data_type            rsp_data_ff, rsp_data_in;
   logic signed [HS_W-1:0]  r_acc [4];

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
         ref_z_ff <= Q14_POS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REF_X: ref_x_ff <= csr_wdata;
            CSR_REF_Y: ref_y_ff <= csr_wdata;
            CSR_REF_Z: ref_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // point into the pose frame
   always_comb begin
      p1_v_in[0] = V_W'($signed(req_data.target_x)) - V_W'($signed(req_data.trans_x));
      p1_v_in[1] = V_W'($signed(req_data.target_y)) - V_W'($signed(req_data.trans_y));
      p1_v_in[2] = V_W'($signed(req_data.target_z)) - V_W'($signed(req_data.trans_z));
      p1_q_in.x  = req_data.rot_x;
      p1_q_in.y  = req_data.rot_y;
      p1_q_in.z  = req_data.rot_z;
      p1_q_in.w  = req_data.rot_w;
      p1_q_in.ok = 1'b1;

      p2_t_in[0][0] = p1_q_ff.z * p1_v_ff[1];
      p2_t_in[0][1] = p1_q_ff.y * p1_v_ff[2];
      p2_t_in[0][2] = p1_q_ff.w * p1_v_ff[0];
      p2_t_in[1][0] = p1_q_ff.x * p1_v_ff[2];
      p2_t_in[1][1] = p1_q_ff.z * p1_v_ff[0];
      p2_t_in[1][2] = p1_q_ff.w * p1_v_ff[1];
      p2_t_in[2][0] = p1_q_ff.y * p1_v_ff[0];
      p2_t_in[2][1] = p1_q_ff.x * p1_v_ff[1];
      p2_t_in[2][2] = p1_q_ff.w * p1_v_ff[2];
   end

   always_comb begin
      logic signed [S1_W-1:0] acc;
      for (int l = 0; l < 3; l++) begin
         acc = S1_W'(p2_t_ff[l][0]) - S1_W'(p2_t_ff[l][1]) + S1_W'(p2_t_ff[l][2])
             + S1_W'(ROUND_HALF);
         p3_c_in[l] = C_W'(acc >>> FRAC_W);
      end
   end

   always_comb begin
      p4_t_in[0][0] = p3_q_ff.z * p3_c_ff[1];
      p4_t_in[0][1] = p3_q_ff.y * p3_c_ff[2];
      p4_t_in[1][0] = p3_q_ff.x * p3_c_ff[2];
      p4_t_in[1][1] = p3_q_ff.z * p3_c_ff[0];
      p4_t_in[2][0] = p3_q_ff.y * p3_c_ff[0];
      p4_t_in[2][1] = p3_q_ff.x * p3_c_ff[1];
   end

   always_comb begin
      logic signed [S2_W-1:0] acc;
      for (int l = 0; l < 3; l++) begin
         acc = ((S2_W'(p4_t_ff[l][0]) - S2_W'(p4_t_ff[l][1])) <<< 1) + S2_W'(ROUND_HALF);
         p5_w_in[l] = WIDE_W'(p4_v_ff[l]) + WIDE_W'(acc >>> FRAC_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= req_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= p4_valid_ff;
      end
      if (adv) begin
         p1_v_ff <= p1_v_in;
         p1_q_ff <= p1_q_in;
         p2_v_ff <= p1_v_ff;
         p2_q_ff <= p1_q_ff;
         p2_t_ff <= p2_t_in;
         p3_v_ff <= p2_v_ff;
         p3_q_ff <= p2_q_ff;
         p3_c_ff <= p3_c_in;
         p4_v_ff <= p3_v_ff;
         p4_q_ff <= p3_q_ff;
         p4_t_ff <= p4_t_in;
         p5_w_ff <= p5_w_in;
         p5_q_ff <= p4_q_ff;
      end
   end

   always_comb begin
      ua_in.valid   = p5_valid_ff;
      ua_in.comp[0] = p5_w_ff[0];
      ua_in.comp[1] = p5_w_ff[1];
      ua_in.comp[2] = p5_w_ff[2];
      ua_in.comp[3] = '0;
      ua_in.side    = p5_q_ff;
   end

   prdr_unit u_dir_unit (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_data  (ua_in),
      .out_data (ua_out)
   );

   // shortest arc from the reference direction
   always_comb begin
      p6_t_in[0] = ref_y_ff * $signed(ua_out.comp[2]);
      p6_t_in[1] = ref_z_ff * $signed(ua_out.comp[1]);
      p6_t_in[2] = ref_z_ff * $signed(ua_out.comp[0]);
      p6_t_in[3] = ref_x_ff * $signed(ua_out.comp[2]);
      p6_t_in[4] = ref_x_ff * $signed(ua_out.comp[1]);
      p6_t_in[5] = ref_y_ff * $signed(ua_out.comp[0]);
      p6_t_in[6] = ref_x_ff * $signed(ua_out.comp[0]);
      p6_t_in[7] = ref_y_ff * $signed(ua_out.comp[1]);
      p6_t_in[8] = ref_z_ff * $signed(ua_out.comp[2]);
      p6_q_in    = ua_out.side;
      p6_q_in.ok = ua_out.ok;

      p7_sq_in[0] = WIDE_W'(p6_t_ff[0]) - WIDE_W'(p6_t_ff[1]);
      p7_sq_in[1] = WIDE_W'(p6_t_ff[2]) - WIDE_W'(p6_t_ff[3]);
      p7_sq_in[2] = WIDE_W'(p6_t_ff[4]) - WIDE_W'(p6_t_ff[5]);
      p7_sq_in[3] = (WIDE_W'(1) <<< (2 * FRAC_W)) + WIDE_W'(p6_t_ff[6])
                  + WIDE_W'(p6_t_ff[7]) + WIDE_W'(p6_t_ff[8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_valid_ff <= 1'b0;
         p7_valid_ff <= 1'b0;
      end else if (adv) begin
         p6_valid_ff <= ua_out.valid;
         p7_valid_ff <= p6_valid_ff;
      end
      if (adv) begin
         p6_t_ff  <= p6_t_in;
         p6_q_ff  <= p6_q_in;
         p7_sq_ff <= p7_sq_in;
         p7_q_ff  <= p6_q_ff;
      end
   end

   always_comb begin
      ub_in.valid = p7_valid_ff;
      for (int i = 0; i < LANES; i++) begin
         ub_in.comp[i] = p7_sq_ff[i];
      end
      ub_in.side = p7_q_ff;
   end

   prdr_unit u_arc_unit (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_data  (ub_in),
      .out_data (ub_out)
   );

   // hamilton product q * s
   always_comb begin
      p8_degen_in = !(ub_out.ok && ub_out.side.ok);
      for (int i = 0; i < LANES; i++) begin
         s_sel[i] = p8_degen_in ? '0 : $signed(ub_out.comp[i]);
      end
      if (p8_degen_in) s_sel[3] = Q14_POS;

      p8_t_in[0][0] = ub_out.side.w * s_sel[0];
      p8_t_in[0][1] = ub_out.side.x * s_sel[3];
      p8_t_in[0][2] = ub_out.side.y * s_sel[2];
      p8_t_in[0][3] = ub_out.side.z * s_sel[1];
      p8_t_in[1][0] = ub_out.side.w * s_sel[1];
      p8_t_in[1][1] = ub_out.side.x * s_sel[2];
      p8_t_in[1][2] = ub_out.side.y * s_sel[3];
      p8_t_in[1][3] = ub_out.side.z * s_sel[0];
      p8_t_in[2][0] = ub_out.side.w * s_sel[2];
      p8_t_in[2][1] = ub_out.side.x * s_sel[1];
      p8_t_in[2][2] = ub_out.side.y * s_sel[0];
      p8_t_in[2][3] = ub_out.side.z * s_sel[3];
      p8_t_in[3][0] = ub_out.side.w * s_sel[3];
      p8_t_in[3][1] = ub_out.side.x * s_sel[0];
      p8_t_in[3][2] = ub_out.side.y * s_sel[1];
      p8_t_in[3][3] = ub_out.side.z * s_sel[2];
   end

   always_comb begin
      r_acc[0] = HS_W'(p8_t_ff[0][0]) + HS_W'(p8_t_ff[0][1])
               + HS_W'(p8_t_ff[0][2]) - HS_W'(p8_t_ff[0][3]);
      r_acc[1] = HS_W'(p8_t_ff[1][0]) - HS_W'(p8_t_ff[1][1])
               + HS_W'(p8_t_ff[1][2]) + HS_W'(p8_t_ff[1][3]);
      r_acc[2] = HS_W'(p8_t_ff[2][0]) + HS_W'(p8_t_ff[2][1])
               - HS_W'(p8_t_ff[2][2]) + HS_W'(p8_t_ff[2][3]);
      r_acc[3] = HS_W'(p8_t_ff[3][0]) - HS_W'(p8_t_ff[3][1])
               - HS_W'(p8_t_ff[3][2]) - HS_W'(p8_t_ff[3][3]);
      rsp_data_in.out_x      = clamp_q14(r_acc[0]);
      rsp_data_in.out_y      = clamp_q14(r_acc[1]);
      rsp_data_in.out_z      = clamp_q14(r_acc[2]);
      rsp_data_in.out_w      = clamp_q14(r_acc[3]);
      rsp_data_in.degenerate = p8_degen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p8_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         p8_valid_ff  <= ub_out.valid;
         rsp_valid_ff <= p8_valid_ff;
      end
      if (adv) begin
         p8_t_ff     <= p8_t_in;
         p8_degen_ff <= p8_degen_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   `PRDR_ASSERT(a_stall_holds_pipe, !adv |=> $stable(p8_valid_ff) && $stable(p5_valid_ff))
   `PRDR_ASSERT(a_out_x_range, rsp_valid |-> rsp_data.out_x <= Q14_POS && rsp_data.out_x >= Q14_NEG)
   `PRDR_ASSERT(a_out_y_range, rsp_valid |-> rsp_data.out_y <= Q14_POS && rsp_data.out_y >= Q14_NEG)
   `PRDR_ASSERT(a_out_z_range, rsp_valid |-> rsp_data.out_z <= Q14_POS && rsp_data.out_z >= Q14_NEG)
   `PRDR_ASSERT(a_out_w_range, rsp_valid |-> rsp_data.out_w <= Q14_POS && rsp_data.out_w >= Q14_NEG)
   `PRDR_ASSERT_NR(a_reset_clears_out, reset |=> !rsp_valid_ff && !p8_valid_ff)

endmodule

// ===== tb/sv/tb_pose_relative_direction_rotation.sv =====
// testbench for the pose relative direction rotation block: random and directed poses vs a predictor
module tb_pose_relative_direction_rotation;
   timeunit 1ns;
   timeprecision 1ps;

   import prdr_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 140;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_data_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   req_data_type pose_q[$];
   rsp_data_type rotation_q[$];
   longint ref_x, ref_y, ref_z;
   int error_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   pose_relative_direction_rotation uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint round_q14(longint v);
      return (v + (longint'(1) << 13)) >>> 14;
   endfunction

   function automatic longint clamp_q14(longint v);
      if (v > Q14_ONE) return Q14_ONE;
      if (v < -Q14_ONE) return -Q14_ONE;
      return v;
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // scale to unit length in Q2.14, returns 0 for the all-zero vector
   function automatic bit unit_scale(input longint v[4], input int n, output longint o[4]);
      bit [63:0] mag[4];
      bit [63:0] m, sum, nrm, q;
      bit neg[4];
      m = 0;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         o[i] = 0;
         mag[i] = 0;
         neg[i] = 0;
      end
      for (int i = 0; i < n; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? -v[i] : v[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) return 1'b0;
      while (m < (64'd1 << 29)) begin
         m = m << 1;
         for (int i = 0; i < n; i++) mag[i] = mag[i] << 1;
      end
      while (m >= (64'd1 << 30)) begin
         m = m >> 1;
         for (int i = 0; i < n; i++) mag[i] = mag[i] >> 1;
      end
      for (int i = 0; i < n; i++) sum = sum + mag[i] * mag[i];
      nrm = int_sqrt(sum);
      for (int i = 0; i < n; i++) begin
         q = (mag[i] * 64'd16384 + nrm / 2) / nrm;
         o[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic rsp_data_type predict_rotation(req_data_type p);
      longint qx, qy, qz, qw, ux, uy, uz;
      longint v[3], c[3], w[4], d[4], sq[4], s[4], r[4];
      bit ok;
      rsp_data_type res;
      qx = longint'(p.rot_x); qy = longint'(p.rot_y);
      qz = longint'(p.rot_z); qw = longint'(p.rot_w);
      ux = -qx; uy = -qy; uz = -qz;
      v[0] = longint'(p.target_x) - longint'(p.trans_x);
      v[1] = longint'(p.target_y) - longint'(p.trans_y);
      v[2] = longint'(p.target_z) - longint'(p.trans_z);
      c[0] = round_q14(uy * v[2] - uz * v[1] + qw * v[0]);
      c[1] = round_q14(uz * v[0] - ux * v[2] + qw * v[1]);
      c[2] = round_q14(ux * v[1] - uy * v[0] + qw * v[2]);
      w[0] = v[0] + round_q14(2 * (uy * c[2] - uz * c[1]));
      w[1] = v[1] + round_q14(2 * (uz * c[0] - ux * c[2]));
      w[2] = v[2] + round_q14(2 * (ux * c[1] - uy * c[0]));
      w[3] = 0;
      ok = unit_scale(w, 3, d);
      if (ok) begin
         sq[0] = ref_y * d[2] - ref_z * d[1];
         sq[1] = ref_z * d[0] - ref_x * d[2];
         sq[2] = ref_x * d[1] - ref_y * d[0];
         sq[3] = (longint'(1) << 28) + ref_x * d[0] + ref_y * d[1] + ref_z * d[2];
         ok = unit_scale(sq, 4, s);
      end
      if (!ok) begin
         s[0] = 0; s[1] = 0; s[2] = 0; s[3] = Q14_ONE;
      end
      r[0] = qw * s[0] + qx * s[3] + qy * s[2] - qz * s[1];
      r[1] = qw * s[1] - qx * s[2] + qy * s[3] + qz * s[0];
      r[2] = qw * s[2] + qx * s[1] - qy * s[0] + qz * s[3];
      r[3] = qw * s[3] - qx * s[0] - qy * s[1] - qz * s[2];
      res.out_x = 16'(clamp_q14(round_q14(r[0])));
      res.out_y = 16'(clamp_q14(round_q14(r[1])));
      res.out_z = 16'(clamp_q14(round_q14(r[2])));
      res.out_w = 16'(clamp_q14(round_q14(r[3])));
      res.degenerate = !ok;
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) rotation_q.push_back(predict_rotation(req_data));
         if (!req_valid || !req_stall) begin
            if (pose_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pose_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < stall_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_data_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rotation_q.size() == 0) begin
            $display("%0t unexpected transaction: got %h", $realtime, rsp_data);
            error_count++;
         end else begin
            e = rotation_q.pop_front();
            if (rsp_data.out_x !== e.out_x) begin
               $display("%0t out_x: expected %0d got %0d", $realtime, e.out_x, rsp_data.out_x);
               error_count++;
            end
            if (rsp_data.out_y !== e.out_y) begin
               $display("%0t out_y: expected %0d got %0d", $realtime, e.out_y, rsp_data.out_y);
               error_count++;
            end
            if (rsp_data.out_z !== e.out_z) begin
               $display("%0t out_z: expected %0d got %0d", $realtime, e.out_z, rsp_data.out_z);
               error_count++;
            end
            if (rsp_data.out_w !== e.out_w) begin
               $display("%0t out_w: expected %0d got %0d", $realtime, e.out_w, rsp_data.out_w);
               error_count++;
            end
            if (rsp_data.degenerate !== e.degenerate) begin
               $display("%0t degenerate: expected %0d got %0d", $realtime, e.degenerate,
                        rsp_data.degenerate);
               error_count++;
            end
         end
      end
   end

   task automatic write_ref(logic [CSR_INDEX_W-1:0] idx, logic signed [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_REF_X: ref_x = longint'(val);
         CSR_REF_Y: ref_y = longint'(val);
         CSR_REF_Z: ref_z = longint'(val);
         default: ;
      endcase
   endtask

   task automatic set_ref(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
      write_ref(CSR_REF_X, x);
      write_ref(CSR_REF_Y, y);
      write_ref(CSR_REF_Z, z);
   endtask

   task automatic wait_idle();
      while (pose_q.size() > 0 || rotation_q.size() > 0 || req_valid) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_pose(int rx, int ry, int rz, int rw, int tx, int ty, int tz,
                           int px, int py, int pz);
      req_data_type p;
      p.rot_x = 16'(rx); p.rot_y = 16'(ry); p.rot_z = 16'(rz); p.rot_w = 16'(rw);
      p.trans_x = tx; p.trans_y = ty; p.trans_z = tz;
      p.target_x = px; p.target_y = py; p.target_z = pz;
      pose_q.push_back(p);
   endtask

   function automatic int rand_unit();
      return $urandom_range(32768) - 16384;
   endfunction

   function automatic int rand_pos();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(2000) - 1000;
         default: return $urandom_range(1 << 22) - (1 << 21);
      endcase
   endfunction

   task automatic add_random(int count);
      int tx, ty, tz, k;
      for (int i = 0; i < count; i++) begin
         tx = rand_pos(); ty = rand_pos(); tz = rand_pos();
         case ($urandom_range(19))
            0: add_pose(rand_unit(), rand_unit(), rand_unit(), rand_unit(),
                        tx, ty, tz, tx, ty, tz);
            1, 2: begin
               k = $urandom_range(1000, 1) * (($urandom_range(1) != 0) ? 1 : -1);
               add_pose(0, 0, 0, Q14_ONE, 0, 0, 0, int'(ref_x) * k, int'(ref_y) * k,
                        int'(ref_z) * k);
            end
            3: add_pose(rand_unit(), rand_unit(), rand_unit(), rand_unit(),
                        $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            default: add_pose(rand_unit(), rand_unit(), rand_unit(), rand_unit(),
                              tx, ty, tz, rand_pos(), rand_pos(), rand_pos());
         endcase
      end
   endtask

   initial begin
      ref_x = 0; ref_y = 0; ref_z = Q14_ONE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      add_pose(0, 0, 0, Q14_ONE, 0, 0, 0, 0, 0, 65536);
      add_pose(0, 0, 0, Q14_ONE, 0, 0, 0, 0, 0, -65536);
      add_pose(0, 0, 0, Q14_ONE, 100, 200, 300, 100, 200, 300);
      add_pose(-16384, -16384, -16384, -16384, 0, 0, 0, 65536, 0, 0);
      add_pose(16384, 16384, 16384, 16384, 0, 0, 0, 0, 65536, 0);
      add_pose(16384, -16384, 16384, -16384, -2147483648, 2147483647, -2147483648,
               2147483647, -2147483648, 2147483647);
      add_pose(-16384, 16384, -16384, 16384, 2147483647, -2147483648, 2147483647,
               -2147483648, 2147483647, -2147483648);
      add_pose(11585, 0, 0, 11585, 1, 1, 1, 2, 3, 4);
      add_pose(0, 11585, 0, -11585, 0, 0, 0, 1, 0, 0);
      add_pose(0, 0, 16384, 0, 0, 0, 0, 0, 0, -1);
      add_pose(16384, 0, 0, 0, 0, 0, 0, 0, 0, 1);
      add_pose(0, 0, 0, 0, 5, 5, 5, 6, 7, 8);
      add_pose(-1, -1, -1, -1, -1, -1, -1, 0, 0, 0);
      add_pose(16384, 16384, 0, 16384, 0, 0, 0, 0, 0, -2147483648);
      wait_idle();
      write_ref(CSR_UNUSED, 16'h1234);
      add_random(120);
      wait_idle();

      // zero reference
      set_ref(0, 0, 0);
      add_pose(0, 0, 0, Q14_ONE, 0, 0, 0, 0, 0, -65536);
      add_pose(16384, 16384, 16384, 16384, 0, 0, 0, 7, 8, 9);
      send_idle_pct = 63;
      add_random(60);
      wait_idle();

      set_ref(16384, 0, 0);
      add_pose(0, 0, 0, Q14_ONE, 0, 0, 0, -65536, 0, 0);
      send_idle_pct = 0;
      stall_pct = 63;
      add_random(100);
      wait_idle();

      set_ref(0, -16384, 0);
      send_idle_pct = 24;
      stall_pct = 24;
      add_random(100);
      wait_idle();

      // long receiver hold-off while the sender keeps offering
      set_ref(-16384, 0, 0);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_request = 1'b1;
      add_random(200);
      wait_idle();

      set_ref(16384, 16384, 16384);
      send_idle_pct = 63;
      stall_pct = 63;
      add_random(80);
      wait_idle();

      set_ref(-16384, -16384, -16384);
      send_idle_pct = 0;
      stall_pct = 0;
      add_random(60);
      wait_idle();

      set_ref(9459, -9459, 9459);
      send_idle_pct = 24;
      stall_pct = 63;
      add_random(80);
      wait_idle();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
